[design/srrp_pkg.sv]
// srrp_pkg: types, constants and codes shared by the serial receive packetizer
// depends on nothing; used by srrp_ctrl, srrp_dpath and serial_rx_ring_packetizer
package srrp_pkg;

	// ring store geometry (power of two, so the write address wraps by truncation)
	localparam int BUF_BYTES = 512;
	localparam int PTR_W     = $clog2(BUF_BYTES);
	localparam int CNT_W     = PTR_W + 1;

	// packet geometry
	localparam int MAX_PKT   = 64;
	localparam int PLEN_W    = 7;
	localparam int LEN_W     = $clog2(MAX_PKT);

	// header bits
	localparam logic [7:0] HDR_DATA_READY = 8'h01;
	localparam logic [7:0] HDR_BREAK      = 8'h10;

	typedef enum logic [1:0] {
		OP_LINE_BYTE = 2'd0,
		OP_BREAK     = 2'd1,
		OP_IN_TOKEN  = 2'd2,
		OP_RESET     = 2'd3
	} op_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_NAK  = 1'b1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [7:0]        data_byte;
		logic [PLEN_W-1:0] packet_length;
		logic [3:0]        modem_lines;
	} in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] packet_byte;
		logic       last;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NAK,
		ST_HDR0,
		ST_HDR1,
		ST_DATA
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_byte;
		logic set_brk;
		logic clr_all;
		logic start_brk;
		logic start_data;
		logic load_nak;
		logic load_hdr0;
		logic load_hdr1;
		logic load_data;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic short_pkt;
		logic brk_set;
		logic empty;
		logic slot_free;
		logic rd_vld;
		logic last_data;
		logic pkt_break;
	} status_t;

endpackage

[design/srrp_ctrl.sv]
// srrp_ctrl: sequencing state machine for the serial receive packetizer
// depends on srrp_pkg (state, command and status types)
module srrp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       operation,
	input  srrp_pkg::status_t st,
	output srrp_pkg::cmd_t    cmd,
	output srrp_pkg::state_t  state
);

	srrp_pkg::state_t state_q;
	srrp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			srrp_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (srrp_pkg::op_t'(operation))
						srrp_pkg::OP_LINE_BYTE: cmd.wr_byte = 1'b1;
						srrp_pkg::OP_BREAK:     cmd.set_brk = 1'b1;
						srrp_pkg::OP_RESET:     cmd.clr_all = 1'b1;
						srrp_pkg::OP_IN_TOKEN: begin
							if (st.short_pkt) begin
								state_d = srrp_pkg::ST_NAK;
							end else if (st.brk_set) begin
								cmd.start_brk = 1'b1;
								state_d       = srrp_pkg::ST_HDR0;
							end else if (st.empty) begin
								state_d = srrp_pkg::ST_NAK;
							end else begin
								cmd.start_data = 1'b1;
								state_d        = srrp_pkg::ST_HDR0;
							end
						end
						default: ;
					endcase
				end
			end
			srrp_pkg::ST_NAK: begin
				if (st.slot_free) begin
					cmd.load_nak = 1'b1;
					state_d      = srrp_pkg::ST_IDLE;
				end
			end
			srrp_pkg::ST_HDR0: begin
				if (st.slot_free) begin
					cmd.load_hdr0 = 1'b1;
					state_d       = srrp_pkg::ST_HDR1;
				end
			end
			srrp_pkg::ST_HDR1: begin
				if (st.slot_free) begin
					cmd.load_hdr1 = 1'b1;
					state_d       = st.pkt_break ? srrp_pkg::ST_IDLE : srrp_pkg::ST_DATA;
				end
			end
			srrp_pkg::ST_DATA: begin
				if (st.slot_free && st.rd_vld) begin
					cmd.load_data = 1'b1;
					if (st.last_data) begin
						state_d = srrp_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = srrp_pkg::ST_IDLE;
		endcase
	end

endmodule

[design/srrp_dpath.sv]
// srrp_dpath: ring store, pointers, break flag, read prefetch and output register
// depends on srrp_pkg (payload, command and status types, geometry constants)
module srrp_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  srrp_pkg::in_t     req,
	input  srrp_pkg::cmd_t    cmd,
	output srrp_pkg::status_t st,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output srrp_pkg::out_t    rsp
);

	logic [7:0]                    mem [srrp_pkg::BUF_BYTES];
	logic [srrp_pkg::PTR_W-1:0]    rd_ptr_q;
	logic [srrp_pkg::CNT_W-1:0]    fill_q;
	logic                          brk_q;
	logic                          pkt_break_q;
	logic [7:0]                    hdr0_q;
	logic [srrp_pkg::LEN_W-1:0]    issue_cnt_q;
	logic [srrp_pkg::LEN_W-1:0]    emit_cnt_q;
	logic [7:0]                    rd_data_q;
	logic                          rd_vld_q;
	srrp_pkg::out_t                out_q;
	logic                          out_vld_q;

	logic [srrp_pkg::PLEN_W-1:0]   plen_c;
	logic [srrp_pkg::LEN_W-1:0]    avail;
	logic [srrp_pkg::LEN_W-1:0]    len;
	logic [srrp_pkg::PTR_W-1:0]    wr_addr;
	logic                          full;
	logic                          issue;

	// clamp the host buffer size, two bytes go to the header
	assign plen_c  = (req.packet_length > srrp_pkg::PLEN_W'(srrp_pkg::MAX_PKT))
		? srrp_pkg::PLEN_W'(srrp_pkg::MAX_PKT) : req.packet_length;
	assign avail   = srrp_pkg::LEN_W'(plen_c - srrp_pkg::PLEN_W'(2));
	assign len     = (srrp_pkg::CNT_W'(avail) > fill_q) ? srrp_pkg::LEN_W'(fill_q) : avail;
	assign wr_addr = rd_ptr_q + fill_q[srrp_pkg::PTR_W-1:0];
	assign full    = (fill_q == srrp_pkg::CNT_W'(srrp_pkg::BUF_BYTES));
	// keep one byte fetched ahead of the output register
	assign issue   = (issue_cnt_q != '0) && (!rd_vld_q || cmd.load_data);

	assign st.short_pkt = (plen_c <= srrp_pkg::PLEN_W'(2));
	assign st.brk_set   = brk_q;
	assign st.empty     = (fill_q == '0);
	assign st.slot_free = !out_vld_q || rsp_ready;
	assign st.rd_vld    = rd_vld_q;
	assign st.last_data = (emit_cnt_q == srrp_pkg::LEN_W'(1));
	assign st.pkt_break = pkt_break_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_byte && !full) begin
			mem[wr_addr] <= req.data_byte;
		end
		if (issue) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			brk_q       <= 1'b0;
			pkt_break_q <= 1'b0;
			issue_cnt_q <= '0;
			emit_cnt_q  <= '0;
			rd_vld_q    <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				rd_ptr_q <= '0;
				fill_q   <= '0;
				brk_q    <= 1'b0;
			end else if (cmd.set_brk) begin
				brk_q <= 1'b1;
			end else if (cmd.wr_byte && !full) begin
				fill_q <= fill_q + srrp_pkg::CNT_W'(1);
			end else if (cmd.start_brk) begin
				brk_q       <= 1'b0;
				pkt_break_q <= 1'b1;
			end else if (cmd.start_data) begin
				pkt_break_q <= 1'b0;
				issue_cnt_q <= len;
				emit_cnt_q  <= len;
			end
			if (issue) begin
				rd_ptr_q    <= rd_ptr_q + srrp_pkg::PTR_W'(1);
				fill_q      <= fill_q - srrp_pkg::CNT_W'(1);
				issue_cnt_q <= issue_cnt_q - srrp_pkg::LEN_W'(1);
				rd_vld_q    <= 1'b1;
			end else if (cmd.load_data) begin
				rd_vld_q <= 1'b0;
			end
			if (cmd.load_data) begin
				emit_cnt_q <= emit_cnt_q - srrp_pkg::LEN_W'(1);
			end
			if (cmd.load_nak || cmd.load_hdr0 || cmd.load_hdr1 || cmd.load_data) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// header byte 0 is latched with the token
	always_ff @(posedge clk) begin
		if (cmd.start_brk || cmd.start_data) begin
			hdr0_q <= {req.modem_lines, 4'b0000} | srrp_pkg::HDR_DATA_READY;
		end
		if (cmd.load_nak) begin
			out_q <= '{kind: srrp_pkg::KIND_NAK, packet_byte: 8'h00, last: 1'b1};
		end else if (cmd.load_hdr0) begin
			out_q <= '{kind: srrp_pkg::KIND_BYTE, packet_byte: hdr0_q, last: 1'b0};
		end else if (cmd.load_hdr1) begin
			out_q <= '{kind: srrp_pkg::KIND_BYTE,
				packet_byte: pkt_break_q ? srrp_pkg::HDR_BREAK : 8'h00,
				last: pkt_break_q};
		end else if (cmd.load_data) begin
			out_q <= '{kind: srrp_pkg::KIND_BYTE, packet_byte: rd_data_q,
				last: (emit_cnt_q == srrp_pkg::LEN_W'(1))};
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

[design/serial_rx_ring_packetizer.sv]
// serial_rx_ring_packetizer: top level of the serial receive packetizer
// instantiates srrp_ctrl and srrp_dpath; types and constants from srrp_pkg
// usage
//   req channel (req_valid/req_ready/req) carries one beat per event: a received
//   line byte, a break, a bulk IN token, or a queue reset
//   rsp channel (rsp_valid/rsp_ready/rsp) carries one beat per packet byte or NAK,
//   with last set on the final beat of each token
// timing
//   line byte, break and reset beats are taken in idle and give no response
//   a token is taken in idle, then its n response beats are loaded into the
//   output register at one per cycle while the receiver keeps up; req_ready is
//   low until the last beat is loaded
//   data bytes come from a single-port ring store with registered read data;
//   one byte is fetched ahead during the header so the store port gives one
//   byte a cycle while the receiver keeps up
// reset
//   arst_n clears pointers, fill count, break flag and output valid; store not cleared
// stalls
//   while rsp_ready is low the output register holds its beat and the sequencer waits;
//   the next request is taken while the final beat of a token still waits
module serial_rx_ring_packetizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  srrp_pkg::in_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output srrp_pkg::out_t rsp
);

	srrp_pkg::cmd_t    cmd;
	srrp_pkg::status_t st;
	srrp_pkg::state_t  state;

	// sequencer: decodes requests and paces the response beats
	srrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (req.operation),
		.st        (st),
		.cmd       (cmd),
		.state     (state)
	);

	// ring store, queue bookkeeping and output register
	srrp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// a nak beat is always the only and final beat with a zero byte
	a_nak_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == srrp_pkg::KIND_NAK) |-> rsp.last && (rsp.packet_byte == 8'h00))
		else $error("nak beat malformed");

	// at most one source loads the output register in a cycle
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_nak, cmd.load_hdr0, cmd.load_hdr1, cmd.load_data}))
		else $error("conflicting output loads");

	// a data beat is only loaded from a fetched byte
	a_data_fetched: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_data |-> st.rd_vld && (state == srrp_pkg::ST_DATA))
		else $error("data beat loaded without fetched byte");

	// after the header of a break report, the sequencer returns to idle
	a_brk_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_hdr1 && st.pkt_break |=> (state == srrp_pkg::ST_IDLE))
		else $error("break report did not end after two beats");
`endif

endmodule

[verif/srrp_packet_checker.sv]
// srrp_packet_checker: watches both channels of the serial receive packetizer, keeps
// its own model of ring store, break flag and IN packet build, and compares rsp beats
// depends on srrp_pkg for the beat structs, op codes and header constants
module srrp_packet_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  srrp_pkg::in_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  srrp_pkg::out_t rsp,
	output int             fail_count,
	output int             beats_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]     ring_mem [srrp_pkg::BUF_BYTES];
	int             rd_ptr;
	int             fill_cnt;
	logic           brk_flag;
	srrp_pkg::out_t owed_q [$];

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic owe(logic kind, logic [7:0] b, logic last);
		srrp_pkg::out_t beat;
		beat.kind        = kind;
		beat.packet_byte = b;
		beat.last        = last;
		owed_q.push_back(beat);
	endtask

	// model of one accepted request beat
	task automatic apply_event(srrp_pkg::in_t ev);
		int         plen;
		int         take;
		logic [7:0] hdr0;
		case (srrp_pkg::op_t'(ev.operation))
			srrp_pkg::OP_LINE_BYTE: begin
				// dropped when the ring is full
				if (fill_cnt < srrp_pkg::BUF_BYTES) begin
					ring_mem[srrp_pkg::PTR_W'((rd_ptr + fill_cnt) % srrp_pkg::BUF_BYTES)] =
						ev.data_byte;
					fill_cnt++;
				end
			end
			srrp_pkg::OP_BREAK: begin
				brk_flag = 1'b1;
			end
			srrp_pkg::OP_RESET: begin
				rd_ptr   = 0;
				fill_cnt = 0;
				brk_flag = 1'b0;
			end
			srrp_pkg::OP_IN_TOKEN: begin
				plen = ev.packet_length;
				if (plen > srrp_pkg::MAX_PKT)
					plen = srrp_pkg::MAX_PKT;
				hdr0 = {ev.modem_lines, 4'h0} | srrp_pkg::HDR_DATA_READY;
				if (plen <= 2) begin
					owe(srrp_pkg::KIND_NAK, 8'h00, 1'b1);
				end else if (brk_flag) begin
					brk_flag = 1'b0;
					owe(srrp_pkg::KIND_BYTE, hdr0, 1'b0);
					owe(srrp_pkg::KIND_BYTE, srrp_pkg::HDR_BREAK, 1'b1);
				end else if (fill_cnt == 0) begin
					owe(srrp_pkg::KIND_NAK, 8'h00, 1'b1);
				end else begin
					take = plen - 2;
					if (take > fill_cnt)
						take = fill_cnt;
					owe(srrp_pkg::KIND_BYTE, hdr0, 1'b0);
					owe(srrp_pkg::KIND_BYTE, 8'h00, 1'b0);
					for (int i = 0; i < take; i++) begin
						owe(srrp_pkg::KIND_BYTE, ring_mem[srrp_pkg::PTR_W'(rd_ptr)],
							i == take - 1);
						rd_ptr = (rd_ptr + 1) % srrp_pkg::BUF_BYTES;
					end
					fill_cnt -= take;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_beat(srrp_pkg::out_t got);
		srrp_pkg::out_t want;
		if (owed_q.size() == 0) begin
			report_mismatch($sformatf("rsp beat %h arrived with nothing owed", got));
			return;
		end
		want = owed_q.pop_front();
		if (got.kind !== want.kind)
			report_mismatch($sformatf("rsp kind %b, expected %b", got.kind, want.kind));
		if (got.packet_byte !== want.packet_byte)
			report_mismatch($sformatf("rsp packet_byte %h, expected %h",
				got.packet_byte, want.packet_byte));
		if (got.last !== want.last)
			report_mismatch($sformatf("rsp last %b, expected %b", got.last, want.last));
	endtask

	// rsp first: a beat taken on the edge that takes a token belongs to an older token
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr     = 0;
			fill_cnt   = 0;
			brk_flag   = 1'b0;
			fail_count = 0;
			owed_q.delete();
		end else begin
			if (rsp_valid && rsp_ready)
				check_beat(rsp);
			if (req_valid && req_ready)
				apply_event(req);
		end
		beats_owed = owed_q.size();
	end

endmodule

[verif/tb_serial_rx_ring_packetizer.sv]
// tb_serial_rx_ring_packetizer: stimulus, rsp back-pressure, watchdog and verdict
// depends on srrp_pkg, serial_rx_ring_packetizer and srrp_packet_checker
module tb_serial_rx_ring_packetizer;
	timeunit 1ns;
	timeprecision 1ps;

	// no handshake on either channel for this long means the block is stuck
	localparam int WATCHDOG_LIMIT = 1000;

	logic           clk;
	logic           arst_n;
	logic           req_valid = 1'b0;
	logic           req_ready;
	srrp_pkg::in_t  req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	srrp_pkg::out_t rsp;
	int             fail_count;
	int             beats_owed;
	int             idle_cycles = 0;

	// stretches where one side never idles
	int    req_run_left = 0;
	int    rsp_run_left = 0;
	int    rsp_stall_left = 0;
	int    rsp_pick;

	serial_rx_ring_packetizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	srrp_packet_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.beats_owed (beats_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: mostly ready, short stalls often, long stalls now and then
	always @(posedge clk) begin
		if (rsp_stall_left > 0) begin
			rsp_stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			if (rsp_run_left > 0) begin
				rsp_run_left--;
			end else begin
				rsp_pick = $urandom_range(0, 99);
				if (rsp_pick < 3)
					rsp_run_left = $urandom_range(20, 80);
				else if (rsp_pick < 25)
					rsp_stall_left = $urandom_range(1, 3);
				else if (rsp_pick < 28)
					rsp_stall_left = $urandom_range(10, 40);
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic srrp_pkg::in_t make_ev(srrp_pkg::op_t op, logic [7:0] b,
		logic [srrp_pkg::PLEN_W-1:0] plen, logic [3:0] lines);
		srrp_pkg::in_t ev;
		ev.operation     = op;
		ev.data_byte     = b;
		ev.packet_length = plen;
		ev.modem_lines   = lines;
		return ev;
	endfunction

	// token sizes: mostly short packets, some full ones, a few too short or clamped
	function automatic logic [srrp_pkg::PLEN_W-1:0] random_plen();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return srrp_pkg::PLEN_W'($urandom_range(0, 2));
		else if (pick == 1)
			return srrp_pkg::PLEN_W'($urandom_range(srrp_pkg::MAX_PKT + 1,
				(1 << srrp_pkg::PLEN_W) - 1));
		else if (pick < 5)
			return srrp_pkg::PLEN_W'($urandom_range(11, srrp_pkg::MAX_PKT));
		else
			return srrp_pkg::PLEN_W'($urandom_range(3, 10));
	endfunction

	// unused fields carry noise so every bit of every field toggles
	function automatic srrp_pkg::in_t random_ev();
		int             pick;
		srrp_pkg::op_t  op;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			op = srrp_pkg::OP_LINE_BYTE;
		else if (pick < 60)
			op = srrp_pkg::OP_BREAK;
		else if (pick < 97)
			op = srrp_pkg::OP_IN_TOKEN;
		else
			op = srrp_pkg::OP_RESET;
		return make_ev(op, 8'($urandom), random_plen(), 4'($urandom));
	endfunction

	// sender idling; valid stays high through a zero gap
	task automatic pause_sender();
		int gap;
		int pick;
		gap = 0;
		if (req_run_left > 0) begin
			req_run_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				req_run_left = $urandom_range(20, 60);
			else if (pick < 50)
				gap = 0;
			else if (pick < 92)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_beat(srrp_pkg::in_t ev);
		req       <= ev;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pause_sender();
	endtask

	// hold off the sender until every owed rsp beat has come back
	task automatic wait_all_owed();
		req_valid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: NAK on an empty queue, short packets, break handling
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd3, 4'hF));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'hFF, 7'd0, 4'hF));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd2, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_BREAK, 8'h00, 7'd0, 4'h0));
		// a short packet leaves the break flag alone
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd1, 4'h5));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd3, 4'h5));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd3, 4'h5));

		// data packets: one byte, then clamped length
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'h00, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'hFF, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'hA5, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'h5A, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd3, 4'hA));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd127, 4'hF));

		// break wins over queued data and leaves the queue intact
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'h3C, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_BREAK, 8'h00, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd64, 4'h3));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd64, 4'h0));

		// queue reset drops data and the break flag
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'h81, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_BREAK, 8'h00, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_RESET, 8'hFF, 7'd127, 4'hF));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd64, 4'hC));
		send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'h7E, 7'd0, 4'h0));
		send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'h00, 7'd65, 4'h9));
		wait_all_owed();

		// flood past full so bytes get dropped, then drain in full packets
		repeat (srrp_pkg::BUF_BYTES + 8)
			send_beat(make_ev(srrp_pkg::OP_LINE_BYTE, 8'($urandom),
				srrp_pkg::PLEN_W'($urandom), 4'($urandom)));
		repeat (srrp_pkg::BUF_BYTES / (srrp_pkg::MAX_PKT - 2) + 2)
			send_beat(make_ev(srrp_pkg::OP_IN_TOKEN, 8'($urandom),
				srrp_pkg::PLEN_W'(srrp_pkg::MAX_PKT), 4'($urandom)));
		wait_all_owed();

		// random traffic, with one full drain halfway through
		for (int i = 0; i < 40; i++) begin
			if (i == 20)
				wait_all_owed();
			send_beat(random_ev());
		end

		wait_all_owed();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && beats_owed == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
